// ===== rtl/bfiq_pkg.sv =====
// Bloom filter insert/query: shared sizes, register codes, hash constants and
// the controller/datapath command and status structs. No dependencies.
package bfiq_pkg;

    localparam int MAX_WORDS  = 1024;
    localparam int MAX_HASHES = 32;

    localparam int KEY_W      = 64;
    localparam int HC_W       = 6;
    localparam int WC_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int ADDR_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int IDX_W    = ADDR_W + 6;
    localparam int WEFF_W   = $clog2(MAX_WORDS + 1);
    localparam int PCNT_W   = $clog2(MAX_HASHES + 1);
    localparam int SPROD_W  = 32 + WEFF_W;
    localparam int SSUM_W   = SPROD_W + 1;
    // bit index = (h * words * 64) >> 64, split as 32-bit halves
    localparam int SCALE_SH = 64 - 6 - 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT = CFG_IDX_W'(1);

    localparam logic [HC_W-1:0] HC_RESET = HC_W'(7);
    localparam logic [WC_W-1:0] WC_RESET = WC_W'(1024);

    localparam logic [63:0] GOLDEN_INC  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] SECOND_SALT = 64'hD1B5_4A32_D192_ED03;

    typedef struct packed {
        logic clr;          // clear-pass write
        logic load;         // latch word, start first hash
        logic pre2;         // start second hash
        logic mul_start;
        logic mul_sel_b;
        logic post_a;
        logic fin_h1;
        logic fin_h2;
        logic scale;        // probe index multiply, advance h
        logic rd;
        logic wr;
        logic emit;
        logic found_val;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mul_done;
        logic words_zero;
        logic probes_done;
        logic is_query;
        logic hit;
    } t_sts;

endpackage

// ===== rtl/bfiq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfiq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bfiq_mul.sv =====
// Iterative 64x64 multiplier, low 64 bits of the product, one 32x32 partial
// product per cycle. Result valid on o_done. No deps.
module bfiq_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic        r_busy;
    logic [1:0]  r_step;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_pp;

    // lo*lo, then the two cross terms; hi*hi falls off the top
    always_comb begin
        case (r_step)
            2'd0: begin
                w_ma = r_a[31:0];
                w_mb = r_b[31:0];
            end
            2'd1: begin
                w_ma = r_a[63:32];
                w_mb = r_b[31:0];
            end
            default: begin
                w_ma = r_a[31:0];
                w_mb = r_b[63:32];
            end
        endcase
    end

    assign w_pp = {32'b0, w_ma} * {32'b0, w_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            r_prod <= w_pp;
            case (r_step)
                2'd0: ;
                2'd1: r_acc <= r_prod;
                default: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/bfiq_dp.sv =====
// Bloom filter datapath: config registers, SplitMix64 hashing, probe index
// scaling, bit store RAM and result register. Uses bfiq_pkg, bfiq_mul, bfiq_ram.
module bfiq_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_func,
    input  logic signed [63:0]             i_key,
    input  logic                           i_cfg_we,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bfiq_pkg::t_cmd                 i_cmd,
    output bfiq_pkg::t_sts                 o_sts,
    output logic                           o_valid,
    output logic                           o_found
);

    logic [bfiq_pkg::HC_W-1:0]    r_hash_count;
    logic [bfiq_pkg::WC_W-1:0]    r_word_count;
    logic                         r_func;
    logic [63:0]                  r_key;
    logic [63:0]                  r_z;
    logic [63:0]                  r_h;
    logic [63:0]                  r_h2;
    logic [bfiq_pkg::SPROD_W-1:0] r_plo;
    logic [bfiq_pkg::SPROD_W-1:0] r_phi;
    logic [bfiq_pkg::ADDR_W-1:0]  r_waddr;
    logic [5:0]                   r_bit;
    logic [bfiq_pkg::PCNT_W-1:0]  r_pcnt;
    logic [bfiq_pkg::ADDR_W-1:0]  r_clr_addr;
    logic                         r_valid;
    logic                         r_found;

    logic [bfiq_pkg::PCNT_W-1:0]  w_probes_eff;
    logic [bfiq_pkg::WEFF_W-1:0]  w_words_eff;
    logic [bfiq_pkg::SSUM_W-1:0]  w_sum;
    logic [bfiq_pkg::IDX_W-1:0]   w_idx;
    logic                         w_mul_done;
    logic [63:0]                  w_prod;
    logic [63:0]                  w_rdata;
    logic                         w_we;
    logic [bfiq_pkg::ADDR_W-1:0]  w_ram_waddr;
    logic [63:0]                  w_ram_wdata;

    function automatic logic [63:0] pre_mix(input logic [63:0] x);
        logic [63:0] z;
        z = x + bfiq_pkg::GOLDEN_INC;
        return z ^ (z >> 30);
    endfunction

    always_comb begin
        if (32'(r_hash_count) > bfiq_pkg::MAX_HASHES) begin
            w_probes_eff = bfiq_pkg::PCNT_W'(bfiq_pkg::MAX_HASHES);
        end else begin
            w_probes_eff = bfiq_pkg::PCNT_W'(r_hash_count);
        end
        if (32'(r_word_count) > bfiq_pkg::MAX_WORDS) begin
            w_words_eff = bfiq_pkg::WEFF_W'(bfiq_pkg::MAX_WORDS);
        end else begin
            w_words_eff = bfiq_pkg::WEFF_W'(r_word_count);
        end
    end

    // high part of h*words*64 from the two registered half products
    assign w_sum = bfiq_pkg::SSUM_W'(r_phi) + bfiq_pkg::SSUM_W'(r_plo >> 32);
    assign w_idx = bfiq_pkg::IDX_W'(w_sum >> bfiq_pkg::SCALE_SH);

    bfiq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (r_z),
        .i_b     (i_cmd.mul_sel_b ? bfiq_pkg::MIX_MUL_B : bfiq_pkg::MIX_MUL_A),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_we        = i_cmd.clr | i_cmd.wr;
    assign w_ram_waddr = i_cmd.clr ? r_clr_addr : r_waddr;
    assign w_ram_wdata = i_cmd.clr ? 64'b0 : (w_rdata | (64'b1 << r_bit));

    bfiq_ram #(
        .WIDTH (64),
        .DEPTH (bfiq_pkg::MAX_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (w_idx[bfiq_pkg::IDX_W-1:6]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count <= bfiq_pkg::HC_RESET;
            r_word_count <= bfiq_pkg::WC_RESET;
            r_pcnt       <= '0;
            r_clr_addr   <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bfiq_pkg::CFG_HASH_COUNT: r_hash_count <= i_cfg_data[bfiq_pkg::HC_W-1:0];
                    bfiq_pkg::CFG_WORD_COUNT: r_word_count <= i_cfg_data[bfiq_pkg::WC_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_pcnt <= '0;
            end else if (i_cmd.scale) begin
                r_pcnt <= r_pcnt + bfiq_pkg::PCNT_W'(1);
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + bfiq_pkg::ADDR_W'(1);
            end
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key  <= i_key;
            r_z    <= pre_mix(i_key);
        end
        if (i_cmd.pre2) begin
            r_z <= pre_mix(r_key ^ bfiq_pkg::SECOND_SALT);
        end
        if (i_cmd.post_a) begin
            r_z <= w_prod ^ (w_prod >> 27);
        end
        if (i_cmd.fin_h1) begin
            r_h <= w_prod ^ (w_prod >> 31);
        end
        if (i_cmd.fin_h2) begin
            r_h2 <= (w_prod ^ (w_prod >> 31)) | 64'd1;
        end
        if (i_cmd.scale) begin
            r_plo <= bfiq_pkg::SPROD_W'(r_h[31:0]) * bfiq_pkg::SPROD_W'(w_words_eff);
            r_phi <= bfiq_pkg::SPROD_W'(r_h[63:32]) * bfiq_pkg::SPROD_W'(w_words_eff);
            r_h   <= r_h + r_h2;
        end
        if (i_cmd.rd) begin
            r_waddr <= w_idx[bfiq_pkg::IDX_W-1:6];
            r_bit   <= w_idx[5:0];
        end
        if (i_cmd.emit) begin
            r_found <= i_cmd.found_val;
        end
    end

    assign o_sts.clr_last    = (r_clr_addr == bfiq_pkg::ADDR_W'(bfiq_pkg::MAX_WORDS - 1));
    assign o_sts.mul_done    = w_mul_done;
    assign o_sts.words_zero  = (w_words_eff == '0);
    assign o_sts.probes_done = (r_pcnt == w_probes_eff);
    assign o_sts.is_query    = r_func;
    assign o_sts.hit         = w_rdata[r_bit];

    assign o_valid = r_valid;
    assign o_found = r_found;

endmodule

// ===== rtl/bfiq_ctrl.sv =====
// Bloom filter controller: clear pass, two-hash sequence and probe loop.
// Drives the datapath through bfiq_pkg::t_cmd, reads bfiq_pkg::t_sts.
module bfiq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bfiq_pkg::t_sts i_sts,
    output bfiq_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MA   = 4'd2;
    localparam logic [3:0] S_WA   = 4'd3;
    localparam logic [3:0] S_MB   = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_PM   = 4'd6;
    localparam logic [3:0] S_PR   = 4'd7;
    localparam logic [3:0] S_PC   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_second;
    logic       n_second;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_second   = 1'b0;
                    n_state    = S_MA;
                end
            end
            S_MA: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_WA;
            end
            S_WA: begin
                if (i_sts.mul_done) begin
                    o_cmd.post_a = 1'b1;
                    n_state      = S_MB;
                end
            end
            S_MB: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel_b = 1'b1;
                n_state         = S_WB;
            end
            S_WB: begin
                if (i_sts.mul_done) begin
                    if (!r_second) begin
                        // h1 done; second hash starts from the salted key
                        o_cmd.fin_h1 = 1'b1;
                        o_cmd.pre2   = 1'b1;
                        n_second     = 1'b1;
                        n_state      = S_MA;
                    end else begin
                        o_cmd.fin_h2 = 1'b1;
                        n_state      = S_PM;
                    end
                end
            end
            S_PM: begin
                if (i_sts.words_zero) begin
                    o_cmd.emit      = i_sts.is_query;
                    o_cmd.found_val = 1'b0;
                    n_state         = S_IDLE;
                end else if (i_sts.probes_done) begin
                    o_cmd.emit      = i_sts.is_query;
                    o_cmd.found_val = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.scale = 1'b1;
                    n_state     = S_PR;
                end
            end
            S_PR: begin
                o_cmd.rd = 1'b1;
                n_state  = S_PC;
            end
            S_PC: begin
                if (!i_sts.is_query) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_PM;
                end else if (!i_sts.hit) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.found_val = 1'b0;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_PM;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/bloom_filter_insert_query.sv =====
// Bloom filter with double hashing, insert and query, top level.
// Uses bfiq_pkg, bfiq_ctrl, bfiq_dp (which holds bfiq_mul and bfiq_ram).
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+---------------------------
//   command  | in        | i_start, o_busy              | i_func, i_key
//   result   | out       | o_valid (one-cycle strobe)   | o_found
//   config   | in        | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A word is taken when i_start is high and o_busy is low. Hashing runs two
// SplitMix64 mixes, each two 64-bit multiplies on one shared 32x32 multiplier;
// each probe runs an index multiply, a store read and a check or write; a query
// ends early at its first clear bit. The query answer strobes in the first cycle
// with o_busy low. After reset a clearing pass zeroes every word of the bit store
// with o_busy high; config writes are taken only while idle with no word offered.
// Results cannot be stalled.
module bloom_filter_insert_query (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_func,
    input  logic signed [63:0]             i_key,
    output logic                           o_valid,
    output logic                           o_found,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bfiq_pkg::t_cmd w_cmd;
    bfiq_pkg::t_sts w_sts;

    // no config change while a word is in flight or being taken
    assign o_cfg_ready = ~o_busy & ~i_start;

    bfiq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    bfiq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_found     (o_found)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_store_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr, w_cmd.wr, w_cmd.rd}))
        else $error("conflicting bit store accesses");

    a_mul_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.mul_done |-> !w_cmd.mul_start)
        else $error("multiplier restarted on its done cycle");

endmodule

// ===== tb/sv/bloom_filter_insert_query_tb.sv =====
// Self-checking testbench for bloom_filter_insert_query: a directed table and then random
// insert/query traffic; query answers checked against a bit-level model or pinned values.
// Depends on bfiq_pkg and the bloom_filter_insert_query RTL.
module bloom_filter_insert_query_tb;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic [bfiq_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = bfiq_pkg::CFG_IDX_W'(2);
    localparam logic [bfiq_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = bfiq_pkg::CFG_IDX_W'(3);

    localparam logic [63:0] KEY_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int IDLE_PCT       = 24;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 100;
    localparam int KEY_POOL_MAX   = 48;

    typedef struct packed {
        logic                            is_cfg;
        logic                            func;
        logic [63:0]                     key;
        logic [bfiq_pkg::CFG_IDX_W-1:0]  idx;
        logic [bfiq_pkg::CFG_DATA_W-1:0] data;
        logic                            pinned;
        logic                            pin_found;
    } t_step;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_start;
    logic                            o_busy;
    logic                            i_func;
    logic signed [63:0]              i_key;
    logic                            o_valid;
    logic                            o_found;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [bfiq_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bfiq_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // filter model state
    logic [63:0]               shadow_bits [bfiq_pkg::MAX_WORDS];
    logic [bfiq_pkg::HC_W-1:0] shadow_hc;
    logic [bfiq_pkg::WC_W-1:0] shadow_wc;
    bit                        found_q [$];

    bit pin_active;
    bit pin_found;
    int idle_pct;
    int fail_count = 0;
    int stall_cycles = 0;

    bloom_filter_insert_query dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_func      (i_func),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] splitmix64(input logic [63:0] x);
        logic [63:0] z;
        z = x + bfiq_pkg::GOLDEN_INC;
        z = (z ^ (z >> 30)) * bfiq_pkg::MIX_MUL_A;
        z = (z ^ (z >> 27)) * bfiq_pkg::MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Applies one word to the filter model; has_answer is set for queries.
    function automatic void filter_step(input logic func, input logic [63:0] key,
                                        output bit has_answer, output bit answer);
        int          probes;
        int unsigned nbits;
        int          word;
        logic [63:0] h;
        logic [63:0] stride;
        logic [127:0] prod;
        logic [63:0] bit_idx;
        bit          hit;
        probes     = (shadow_hc > bfiq_pkg::MAX_HASHES) ? bfiq_pkg::MAX_HASHES
                                                        : int'(shadow_hc);
        nbits      = ((shadow_wc > bfiq_pkg::MAX_WORDS) ? bfiq_pkg::MAX_WORDS
                                                        : int'(shadow_wc)) * 64;
        has_answer = (func == FUNC_QUERY);
        answer     = 1'b0;
        if (nbits == 0)
            return;
        h      = splitmix64(key);
        stride = splitmix64(key ^ bfiq_pkg::SECOND_SALT) | 64'd1;
        hit    = 1'b1;
        for (int i = 0; i < probes; i++) begin
            // bit index is the high half of h * nbits
            prod    = {64'd0, h} * 128'(nbits);
            bit_idx = prod[127:64];
            word    = (bit_idx[63:6] >= bfiq_pkg::MAX_WORDS) ? bfiq_pkg::MAX_WORDS - 1
                                                             : int'(bit_idx[63:6]);
            if (func == FUNC_INSERT) begin
                shadow_bits[word][bit_idx[5:0]] = 1'b1;
            end else if (!shadow_bits[word][bit_idx[5:0]]) begin
                hit = 1'b0;
                break;
            end
            h = h + stride;
        end
        answer = hit;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch %0d: %s", fail_count, msg);
    endfunction

    function automatic t_step item_row(input logic func, input logic [63:0] key);
        t_step s;
        s      = '0;
        s.func = func;
        s.key  = key;
        return s;
    endfunction

    function automatic t_step pinned_row(input logic [63:0] key, input logic want);
        t_step s;
        s           = item_row(FUNC_QUERY, key);
        s.pinned    = 1'b1;
        s.pin_found = want;
        return s;
    endfunction

    function automatic t_step cfg_row(input logic [bfiq_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [bfiq_pkg::CFG_DATA_W-1:0] data);
        t_step s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    always @(posedge i_clk) begin : answer_check
        bit has_answer;
        bit answer;
        bit want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (found_q.size() == 0) begin
                    note_failure($sformatf("unexpected answer, found=%0b", o_found));
                end else begin
                    want = found_q.pop_front();
                    if (o_found !== want)
                        note_failure($sformatf("found: expected %0b, got %0b", want, o_found));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bfiq_pkg::CFG_HASH_COUNT)
                    shadow_hc = i_cfg_data[bfiq_pkg::HC_W-1:0];
                else if (i_cfg_index == bfiq_pkg::CFG_WORD_COUNT)
                    shadow_wc = i_cfg_data[bfiq_pkg::WC_W-1:0];
            end
            if (i_start && !o_busy) begin
                filter_step(i_func, i_key, has_answer, answer);
                if (has_answer)
                    found_q.push_back(pin_active ? pin_found : answer);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Lowers both requests and waits until the block is idle with no answer pending.
    task automatic drain();
        i_start     <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (found_q.size() != 0 || o_busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        while (found_q.size() != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic send_word(input logic func, input logic [63:0] key,
                             input bit pinned, input bit want);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start    <= 1'b1;
        i_func     <= func;
        i_key      <= key;
        pin_active = pinned;
        pin_found  = want;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [bfiq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfiq_pkg::CFG_DATA_W-1:0] data);
        drain();
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    initial begin
        t_step                           directed [$];
        logic [63:0]                     key_pool [$];
        logic [63:0]                     k;
        logic [bfiq_pkg::CFG_DATA_W-1:0] hc_data;
        logic [bfiq_pkg::CFG_DATA_W-1:0] wc_data;
        int                              r;
        int                              n_items;

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_func      <= FUNC_INSERT;
        i_key       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bfiq_pkg::CFG_HASH_COUNT;
        i_cfg_data  <= '0;
        foreach (shadow_bits[w])
            shadow_bits[w] = '0;
        shadow_hc  = bfiq_pkg::HC_RESET;
        shadow_wc  = bfiq_pkg::WC_RESET;
        pin_active = 1'b0;
        pin_found  = 1'b0;
        idle_pct   = IDLE_PCT;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        drain();    // covers the clearing pass

        directed = '{
            pinned_row(64'd0, 1'b0),                   // empty filter
            pinned_row(KEY_MAX, 1'b0),
            item_row(FUNC_INSERT, 64'd0),
            pinned_row(64'd0, 1'b1),
            item_row(FUNC_INSERT, KEY_MIN),
            item_row(FUNC_INSERT, KEY_ONES),
            pinned_row(KEY_MIN, 1'b1),
            pinned_row(KEY_ONES, 1'b1),
            item_row(FUNC_QUERY, KEY_MAX),
            cfg_row(bfiq_pkg::CFG_HASH_COUNT, 11'd0),  // no probes: query always hits
            pinned_row(64'd12345, 1'b1),
            item_row(FUNC_INSERT, 64'h5555_5555_5555_5555),
            cfg_row(bfiq_pkg::CFG_HASH_COUNT, 11'h7FF), // 63 probes saturate at 32
            item_row(FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA),
            pinned_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1),
            cfg_row(bfiq_pkg::CFG_HASH_COUNT, 11'h041), // upper bits dropped: one probe
            item_row(FUNC_QUERY, 64'h5555_5555_5555_5555),
            cfg_row(bfiq_pkg::CFG_WORD_COUNT, 11'd0),  // empty store: query always misses
            item_row(FUNC_INSERT, KEY_ONES),
            pinned_row(KEY_ONES, 1'b0),
            cfg_row(bfiq_pkg::CFG_WORD_COUNT, 11'd1),
            item_row(FUNC_INSERT, 64'd5),
            pinned_row(64'd5, 1'b1),
            item_row(FUNC_QUERY, 64'd6),
            cfg_row(bfiq_pkg::CFG_WORD_COUNT, 11'h7FF), // saturates at full size
            item_row(FUNC_QUERY, 64'd0),
            cfg_row(CFG_SPARE_LO, 11'd0),
            cfg_row(CFG_SPARE_HI, 11'h7FF),
            item_row(FUNC_QUERY, KEY_ONES),
            cfg_row(bfiq_pkg::CFG_HASH_COUNT, 11'd32),
            cfg_row(bfiq_pkg::CFG_WORD_COUNT, 11'd1024),
            item_row(FUNC_INSERT, 64'd1),
            pinned_row(64'd1, 1'b1),
            item_row(FUNC_QUERY, 64'd2),
            cfg_row(bfiq_pkg::CFG_WORD_COUNT, 11'd1025),
            pinned_row(64'd1, 1'b1)
        };

        foreach (directed[n]) begin
            if (directed[n].is_cfg)
                write_reg(directed[n].idx, directed[n].data);
            else
                send_word(directed[n].func, directed[n].key,
                          directed[n].pinned, directed[n].pin_found);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct = (ph == 3) ? 0 : IDLE_PCT;
            n_items  = (ph == 5) ? 30 : PHASE_ITEMS;
            case (ph)
                0: begin
                    hc_data = 11'd1;
                    wc_data = 11'd1;
                end
                1: begin
                    hc_data = 11'd32;
                    wc_data = 11'd1024;
                end
                2: begin
                    hc_data = 11'd0;
                    wc_data = bfiq_pkg::CFG_DATA_W'($urandom_range(1, 4));
                end
                3: begin
                    hc_data = bfiq_pkg::CFG_DATA_W'(bfiq_pkg::HC_RESET);
                    wc_data = bfiq_pkg::CFG_DATA_W'(bfiq_pkg::WC_RESET);
                end
                4: begin
                    hc_data = 11'h7FF;
                    wc_data = 11'h7FF;
                end
                5: begin
                    hc_data = 11'd5;
                    wc_data = 11'd0;
                end
                default: begin
                    hc_data = bfiq_pkg::CFG_DATA_W'(($urandom_range(0, 31) << 6)
                                                    | $urandom_range(1, 12));
                    if ($urandom_range(9) == 0)
                        wc_data = bfiq_pkg::CFG_DATA_W'($urandom_range(0, 2047));
                    else
                        wc_data = bfiq_pkg::CFG_DATA_W'($urandom_range(1, 16));
                end
            endcase
            write_reg(bfiq_pkg::CFG_HASH_COUNT, hc_data);
            write_reg(bfiq_pkg::CFG_WORD_COUNT, wc_data);

            for (int n = 0; n < n_items; n++) begin
                r = $urandom_range(99);
                if (r < 40 || key_pool.size() == 0) begin
                    k = {$urandom, $urandom};
                    send_word(FUNC_INSERT, k, 1'b0, 1'b0);
                    key_pool.push_back(k);
                    if (key_pool.size() > KEY_POOL_MAX)
                        key_pool.delete(0);
                end else if (r < 75) begin
                    send_word(FUNC_QUERY, key_pool[$urandom_range(key_pool.size() - 1)],
                              1'b0, 1'b0);
                end else if (r < 95) begin
                    send_word(FUNC_QUERY, {$urandom, $urandom}, 1'b0, 1'b0);
                end else begin
                    // one bit away from a stored key
                    k = key_pool[$urandom_range(key_pool.size() - 1)]
                        ^ (64'd1 << $urandom_range(63));
                    send_word(logic'($urandom_range(1)), k, 1'b0, 1'b0);
                end
                if ($urandom_range(49) == 0)
                    drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
